// ----- rtl/core/reward_curve_evaluator_defines.svh -----
// Assertion macros shared by the checker files.
// Each expects clk and arst_n to be visible where it is used.
`ifndef REWARD_CURVE_EVALUATOR_DEFINES_SVH
`define REWARD_CURVE_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define RCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rce_pkg.sv -----
`timescale 1ns / 1ps
package rce_pkg;

	// divider geometry
	localparam int DIV_STEPS = 128;
	localparam int NQ_W      = 128;
	localparam int DEN_W     = 67;
	localparam int REM_W     = 68;
	localparam int ASQ_W     = 34;

	// curve codes
	localparam logic [2:0] FN_QUAD    = 3'd0;
	localparam logic [2:0] FN_BOUNDED = 3'd1;
	localparam logic [2:0] FN_LINEAR  = 3'd2;
	localparam logic [2:0] FN_SQRT    = 3'd3;
	localparam logic [2:0] FN_CONV_LIN = 3'd4;
	localparam logic [2:0] FN_CONV_SQRT = 3'd5;

	// one beat inside the divider: numerator shifting out, quotient shifting in
	typedef struct packed {
		logic [NQ_W-1:0]  nq;
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic             flag;
	} div_beat_t;

endpackage

// ----- rtl/core/reward_curve_evaluator.sv -----
`timescale 1ns / 1ps
// Reward curve evaluator.
// Input stream: s_tdata carries the 64-bit share count, s_tuser the curve code.
// Output stream: m_tdata carries the 128-bit claim, m_tuser the divide-by-zero flag.
// The curve constant sits in one 64-bit register at APB address 0; write it
// only while no beat is in flight.
// Every curve passes through the same pipe: four front stages (sum, partial
// products, product sum and root extraction, operand select) and a 128-stage
// restoring divider, one quotient bit per stage. Curves that need no division
// divide by one.
// Throughput is one beat per clock while m_tready is high or m_tvalid is low.
// The whole pipe advances together: when a result waits on m_tready low, all
// stages hold and s_tready drops; while m_tvalid is low the pipe keeps moving
// and fills its bubbles.
// Reset clears all valid bits and the curve constant; no beat is lost or
// repeated across a stall.
module reward_curve_evaluator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,   // shares[63:0]
	input  logic [2:0]    s_tuser,   // func[2:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,   // claim_low[63:0], claim_high[127:64]
	output logic [0:0]    m_tuser,   // divide_by_zero[0]
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [0:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);
	import rce_pkg::*;

	localparam logic [0:0] ADDR_CONST = 1'b0;

	logic [63:0] s_const_q;
	logic        ce;
	logic        v_a    [0:DIV_STEPS];
	div_beat_t   beat_a [0:DIV_STEPS];

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s_const_q <= '0;
		else if (psel && penable && pwrite && paddr == ADDR_CONST) s_const_q <= pwdata;
	end
	assign prdata = (paddr == ADDR_CONST) ? s_const_q : '0;

	// global advance
	assign ce       = m_tready || !m_tvalid;
	assign s_tready = ce;

	rce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (s_tvalid),
		.func     (s_tuser),
		.shares   (s_tdata),
		.s_const  (s_const_q),
		.out_valid(v_a[0]),
		.out_beat (beat_a[0])
	);

	// divider chain
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		rce_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ce       (ce),
			.in_valid (v_a[g]),
			.in_beat  (beat_a[g]),
			.out_valid(v_a[g+1]),
			.out_beat (beat_a[g+1])
		);
	end

	assign m_tvalid   = v_a[DIV_STEPS];
	assign m_tdata    = beat_a[DIV_STEPS].nq;
	assign m_tuser[0] = beat_a[DIV_STEPS].flag;

endmodule

// ----- rtl/core/rce_front.sv -----
`timescale 1ns / 1ps
module rce_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic                in_valid,
	input  logic [2:0]          func,
	input  logic [63:0]         shares,
	input  logic [63:0]         s_const,
	output logic                out_valid,
	output rce_pkg::div_beat_t  out_beat
);
	import rce_pkg::*;

	// index of the top set bit
	function automatic logic [6:0] lead_one(input logic [65:0] x);
		logic [6:0] idx;
		idx = '0;
		for (int i = 0; i < 66; i++) begin
			if (x[i]) idx = 7'(i);
		end
		return idx;
	endfunction

	// approximate square root from a known top-bit index
	function automatic logic [ASQ_W-1:0] asqrt_f(input logic [65:0] x, input logic [6:0] m,
			input logic nz);
		logic [6:0]  z;
		logic [65:0] zbit, mant, lo, hi, res;
		z    = m >> 1;
		zbit = 66'd1 << z;
		mant = x & ((66'd1 << m) - 66'd1);
		lo   = mant >> (m - z);
		hi   = m[0] ? zbit : '0;
		res  = nz ? (zbit | ((hi | lo) >> 1)) : '0;
		return res[ASQ_W-1:0];
	endfunction

	logic              v_s1, v_s2, v_s3;
	logic [2:0]        func_s1, func_s2, func_s3;
	logic [63:0]       r_s1, r_s2, r_s3;
	logic [65:0]       b_s1, b_s2, b_s3;
	logic [66:0]       d4_s1, d4_s2, d4_s3;
	logic [63:0]       p00_s2, p01_s2, p10_s2, p11_s2;
	logic [65:0]       ptop_s2;
	logic [6:0]        mr_s2, mb_s2;
	logic              rnz_s2, bnz_s2;
	logic [127:0]      quad_s3;
	logic [ASQ_W-1:0]  asr_s3, asb_s3;
	div_beat_t         beat_d;
	div_beat_t         beat_s4;
	logic              v_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: capture, form r+2s and r+4s
	always_ff @(posedge clk) begin
		if (ce) begin
			func_s1 <= func;
			r_s1    <= shares;
			b_s1    <= {2'b00, shares} + {1'b0, s_const, 1'b0};
			d4_s1   <= {3'b000, shares} + {1'b0, s_const, 2'b00};
		end
	end

	// s2: partial products of r*(r+2s), top-bit search
	always_ff @(posedge clk) begin
		if (ce) begin
			func_s2 <= func_s1;
			r_s2    <= r_s1;
			b_s2    <= b_s1;
			d4_s2   <= d4_s1;
			p00_s2  <= 64'(r_s1[31:0])  * 64'(b_s1[31:0]);
			p01_s2  <= 64'(r_s1[31:0])  * 64'(b_s1[63:32]);
			p10_s2  <= 64'(r_s1[63:32]) * 64'(b_s1[31:0]);
			p11_s2  <= 64'(r_s1[63:32]) * 64'(b_s1[63:32]);
			ptop_s2 <= (b_s1[64] ? {2'b00, r_s1} : 66'd0)
				+ (b_s1[65] ? {1'b0, r_s1, 1'b0} : 66'd0);
			mr_s2   <= lead_one({2'b00, r_s1});
			mb_s2   <= lead_one(b_s1);
			rnz_s2  <= |r_s1;
			bnz_s2  <= |b_s1;
		end
	end

	// s3: sum the product, shift out the roots
	always_ff @(posedge clk) begin
		if (ce) begin
			func_s3 <= func_s2;
			r_s3    <= r_s2;
			b_s3    <= b_s2;
			d4_s3   <= d4_s2;
			quad_s3 <= {64'd0, p00_s2}
				+ ({64'd0, p01_s2} << 32) + ({64'd0, p10_s2} << 32)
				+ {p11_s2, 64'd0} + {ptop_s2[63:0], 64'd0};
			asr_s3  <= asqrt_f({2'b00, r_s2}, mr_s2, rnz_s2);
			asb_s3  <= asqrt_f(b_s2, mb_s2, bnz_s2);
		end
	end

	// numerator and divisor per curve; plain curves divide by one
	always_comb begin
		beat_d.rem  = '0;
		beat_d.flag = 1'b0;
		beat_d.den  = DEN_W'(1);
		beat_d.nq   = '0;
		case (func_s3)
			FN_QUAD:    beat_d.nq = quad_s3;
			FN_LINEAR:  beat_d.nq = {64'd0, r_s3};
			FN_SQRT:    beat_d.nq = NQ_W'(asr_s3);
			FN_BOUNDED: begin
				if (b_s3 == '0) beat_d.flag = 1'b1;
				else begin
					beat_d.nq  = {r_s3, 64'd0};
					beat_d.den = {1'b0, b_s3};
				end
			end
			FN_CONV_LIN: begin
				if (d4_s3 == '0) beat_d.flag = 1'b1;
				else begin
					beat_d.nq  = quad_s3;
					beat_d.den = d4_s3;
				end
			end
			FN_CONV_SQRT: begin
				if (asb_s3 == '0) beat_d.flag = 1'b1;
				else begin
					beat_d.nq  = {64'd0, r_s3};
					beat_d.den = DEN_W'(asb_s3);
				end
			end
			default: ;
		endcase
	end

	// s4: register the divider operands
	always_ff @(posedge clk) begin
		if (ce) beat_s4 <= beat_d;
	end

	assign out_valid = v_s4;
	assign out_beat  = beat_s4;

endmodule

// ----- rtl/core/rce_div_stage.sv -----
`timescale 1ns / 1ps
module rce_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic                in_valid,
	input  rce_pkg::div_beat_t  in_beat,
	output logic                out_valid,
	output rce_pkg::div_beat_t  out_beat
);
	import rce_pkg::*;

	logic [REM_W-1:0] rem_sh, rem_sub;
	logic             ge;
	logic             valid_q;
	div_beat_t        beat_q;

	// one restoring step: bring in the next numerator bit
	assign rem_sh  = {in_beat.rem[REM_W-2:0], in_beat.nq[NQ_W-1]};
	assign ge      = rem_sh >= {1'b0, in_beat.den};
	assign rem_sub = rem_sh - {1'b0, in_beat.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (ce) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			beat_q.nq   <= {in_beat.nq[NQ_W-2:0], ge};
			beat_q.rem  <= ge ? rem_sub : rem_sh;
			beat_q.den  <= in_beat.den;
			beat_q.flag <= in_beat.flag;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

// ----- rtl/core/rce_checker.sv -----
`timescale 1ns / 1ps
`include "reward_curve_evaluator_defines.svh"
module rce_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tready,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [127:0]  m_tdata,
	input  logic [0:0]    m_tuser
);

	// a stalled output beat holds
	`RCE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed under stall")
	// the pipe stops taking beats while the output is blocked
	`RCE_ASSERT_IMP(a_in_block, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
	// an empty output stage never blocks the input
	`RCE_ASSERT_IMP(a_in_free, !m_tvalid, s_tready, "input blocked with empty output")
	// a zero divisor forces a zero claim
	`RCE_ASSERT_IMP(a_dz_zero, m_tvalid && m_tuser[0], m_tdata == '0, "flagged claim not zero")

endmodule

bind reward_curve_evaluator rce_checker u_rce_checker (.*);
